FILE: src/mkd_pkg.sv
// Package for the Morse key decoder: register indexes, reset values and
// the Morse-to-ASCII lookup table. No dependencies.
`timescale 1ns / 1ps

package mkd_pkg;

    // Configuration register indexes
    localparam logic REG_DASH_THRESHOLD = 1'b0;
    localparam logic REG_GAP_THRESHOLD  = 1'b1;

    // Register reset values
    localparam logic [7:0] DASH_THRESHOLD_RESET = 8'd7;
    localparam logic [7:0] GAP_THRESHOLD_RESET  = 8'd15;

    // Symbol storage depth and the character for unknown groups
    localparam int unsigned MAX_SYMBOLS  = 5;
    localparam logic [6:0]  UNKNOWN_CHAR = 7'h2E;

    typedef logic [7:0] t_tick_cnt;
    typedef logic [2:0] t_sym_cnt;

    // Index is (1 << length) | pattern, first symbol in the MSB.
    localparam logic [64*8-1:0] MORSE_TABLE =
        "..ETIANMSURWDKGOHVF.L.PJBXCYZQ..54.3...2.......16.......7...8.90";

    function automatic logic [6:0] morse_char(input logic [5:0] idx);
        logic [7:0] ch;
        ch = MORSE_TABLE[(7'd63 - {1'b0, idx}) * 8 +: 8];
        return ch[6:0];
    endfunction

endpackage

FILE: src/morse_key_decoder_top.sv
// Morse key decoder top level: key sample channel in, character channel out.
// Depends on mkd_pkg.
`timescale 1ns / 1ps

// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one key sample per
//   transaction. Every accepted sample produces exactly one result
//   transaction on the output channel (o_out_valid / i_out_ready) with the
//   tone level and, when a symbol group is decoded, the character and the
//   display cursor where it goes.
//   The result of an accepted sample is registered and presented from the
//   next cycle on. Throughput is one sample per cycle while results are
//   taken; counters, symbol store and table lookup all update in the
//   single register stage.
//   If the receiver stalls, the result register holds its transaction and
//   o_in_ready drops until the result is taken; a result taken in the same
//   cycle frees the slot for the next sample.
//   Synchronous active-low reset clears counters, symbols and cursor and
//   loads the thresholds with 7 (dash) and 15 (gap). The user writes them
//   via i_cfg_we / i_cfg_index / i_cfg_data only while idle (unenforced).
module morse_key_decoder_top #(
    parameter int LINE_WIDTH = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // configuration write port
    input  logic       i_cfg_we,
    input  logic       i_cfg_index,
    input  logic [7:0] i_cfg_data,
    // key sample channel
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic       i_key_down,
    // result channel
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic       o_tone_on,
    output logic       o_char_valid,
    output logic [6:0] o_char_code,
    output logic [3:0] o_cursor_col,
    output logic       o_cursor_row,
    output logic       o_clear_row
);
    import mkd_pkg::*;

    localparam int COL_W = $clog2(LINE_WIDTH + 1);

    // Configuration
    t_tick_cnt r_dash_thr, r_gap_thr;

    // Decoder state
    t_tick_cnt               r_held, n_held;
    t_tick_cnt               r_gap, n_gap;
    t_sym_cnt                r_count, n_count;
    t_sym_cnt                r_last_slot, n_last_slot;
    logic [MAX_SYMBOLS-1:0]  r_symbols, n_symbols;
    logic                    r_adv_pend, n_adv_pend;
    logic [COL_W-1:0]        r_column, n_column;
    logic                    r_row, n_row;

    // Result register
    logic             r_out_valid;
    logic             r_tone, n_tone;
    logic             r_cvalid, n_cvalid;
    logic [6:0]       r_code, n_code;
    logic [3:0]       r_col, n_col;
    logic             r_crow, n_crow;
    logic             r_clr, n_clr;

    logic             accept;
    logic [COL_W+3:0] col_ext;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;

    // Next state and result for one key sample
    always_comb begin
        t_tick_cnt        held_base;
        logic             decode;
        logic [5:0]       key;
        logic [COL_W-1:0] col_use;

        n_held      = r_held;
        n_gap       = r_gap;
        n_count     = r_count;
        n_last_slot = r_last_slot;
        n_symbols   = r_symbols;
        n_adv_pend  = r_adv_pend;
        n_column    = r_column;
        n_row       = r_row;
        n_tone      = i_key_down;
        n_cvalid    = 1'b0;
        n_code      = '0;
        n_col       = '0;
        n_crow      = 1'b0;
        n_clr       = 1'b0;
        held_base   = r_held;
        decode      = 1'b0;
        key         = '0;
        col_use     = r_column;
        col_ext     = '0;

        if (i_key_down) begin
            // new symbol slot restarts the press length
            if (r_last_slot != r_count)
                held_base = '0;
            n_adv_pend = 1'b1;
            if (r_count < t_sym_cnt'(MAX_SYMBOLS))
                n_symbols[r_count] = (held_base > r_dash_thr);
            n_held      = (&held_base) ? held_base : held_base + 8'd1;
            n_gap       = '0;
            n_last_slot = r_count;
        end else begin
            if (r_gap > r_gap_thr && r_held != '0) begin
                n_held = '0;
                decode = 1'b1;
            end
            // close the symbol when the press has ended
            if (r_adv_pend && n_held != '0 && r_count < t_sym_cnt'(MAX_SYMBOLS)) begin
                n_adv_pend = 1'b0;
                n_count    = r_count + 3'd1;
            end
            n_gap = (&r_gap) ? r_gap : r_gap + 8'd1;
        end

        // Group lookup and cursor placement
        if (decode) begin
            case (r_count)
                3'd1:    key = {5'b00001, r_symbols[0]};
                3'd2:    key = {4'b0001, r_symbols[0], r_symbols[1]};
                3'd3:    key = {3'b001, r_symbols[0], r_symbols[1], r_symbols[2]};
                3'd4:    key = {2'b01, r_symbols[0], r_symbols[1], r_symbols[2],
                                r_symbols[3]};
                3'd5:    key = {1'b1, r_symbols[0], r_symbols[1], r_symbols[2],
                                r_symbols[3], r_symbols[4]};
                default: key = '0;
            endcase
            n_code = (key == '0) ? UNKNOWN_CHAR : morse_char(key);
            if (r_column >= COL_W'(LINE_WIDTH)) begin
                col_use = '0;
                n_row   = !r_row;
                n_clr   = 1'b1;
            end
            col_ext  = {4'b0000, col_use};
            n_col    = col_ext[3:0];
            n_crow   = n_row;
            n_column = col_use + COL_W'(1);
            n_count  = '0;
            n_cvalid = 1'b1;
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dash_thr <= DASH_THRESHOLD_RESET;
            r_gap_thr  <= GAP_THRESHOLD_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_index == REG_DASH_THRESHOLD)
                r_dash_thr <= i_cfg_data;
            else
                r_gap_thr <= i_cfg_data;
        end
    end

    // Decoder state, updated once per accepted transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held      <= '0;
            r_gap       <= '0;
            r_count     <= '0;
            r_last_slot <= '0;
            r_symbols   <= '0;
            r_adv_pend  <= 1'b0;
            r_column    <= '0;
            r_row       <= 1'b0;
        end else if (accept) begin
            r_held      <= n_held;
            r_gap       <= n_gap;
            r_count     <= n_count;
            r_last_slot <= n_last_slot;
            r_symbols   <= n_symbols;
            r_adv_pend  <= n_adv_pend;
            r_column    <= n_column;
            r_row       <= n_row;
        end
    end

    // Result valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_tone   <= n_tone;
            r_cvalid <= n_cvalid;
            r_code   <= n_code;
            r_col    <= n_col;
            r_crow   <= n_crow;
            r_clr    <= n_clr;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_tone_on    = r_tone;
    assign o_char_valid = r_cvalid;
    assign o_char_code  = r_code;
    assign o_cursor_col = r_col;
    assign o_cursor_row = r_crow;
    assign o_clear_row  = r_clr;

endmodule
